@@ hw/rtl/zcf_pkg.sv @@
// ----------------------------------------------------------------------------
// zcf_pkg
// Shared constants, types and helpers for the zero-cross frequency meter.
// ----------------------------------------------------------------------------
package zcf_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int TIME_BITS     = 40;
  localparam int THR_BITS      = 12;
  localparam int PERIODS_BITS  = 8;
  localparam int FREQ_BITS     = 27;
  localparam int DISP_BITS     = 7;
  localparam int SEG_BITS      = 7;
  localparam int DIGIT_BITS    = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;

  // numerator = periods * 1e8, periods < 2^PERIODS_BITS
  localparam int NUM_BITS  = 35;
  localparam int STEP_BITS = $clog2(NUM_BITS);

  localparam logic [FREQ_BITS-1:0]    CENTI_SCALE   = 27'd100000000;
  localparam logic [FREQ_BITS-1:0]    FREQ_MAX      = 27'd100000000;
  localparam logic [FREQ_BITS-1:0]    HELD_RESET    = 27'd5000;
  localparam logic [THR_BITS-1:0]     THR_RESET     = 12'd2048;
  localparam logic [PERIODS_BITS-1:0] PERIODS_RESET = 8'd5;

  // display scaling: hz = (f + 50) / 100, clamped at 99
  localparam logic [DISP_BITS-1:0] DISP_MAX     = 7'd99;
  localparam logic [FREQ_BITS-1:0] ROUND_LIMIT  = 27'd9950;
  localparam int                   RND_BITS     = 14;
  localparam logic [RND_BITS-1:0]  ROUND_BIAS   = 14'd50;
  localparam int                   HZ_PROD_BITS = 27;
  localparam int                   HZ_RECIP     = 5243;  // 2^19 / 100, rounded up
  localparam int                   HZ_SHIFT     = 19;
  localparam int                   TEN_PROD_BITS = 15;
  localparam int                   TEN_RECIP    = 205;   // 2^11 / 10, rounded up
  localparam int                   TEN_SHIFT    = 11;
  localparam logic [DISP_BITS-1:0] DEC_BASE     = 7'd10;

  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_PERIODS   = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_LOAD,
    BK_SCALE,
    BK_EMIT
  } back_state_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic                 crossing;
    logic                 measure;
    logic [NUM_BITS-1:0]  numer;
    logic [TIME_BITS-1:0] divisor;
  } job_t;

  function automatic logic [SEG_BITS-1:0] seg7(input logic [DIGIT_BITS-1:0] digit);
    logic [SEG_BITS-1:0] pat;
    case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

@@ hw/rtl/zcf_if.sv @@
// ----------------------------------------------------------------------------
// zcf channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface zcf_in_if import zcf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_BITS-1:0]   time_us;

  modport source (output valid, output sample, output time_us, input ready);
  modport sink   (input valid, input sample, input time_us, output ready);
endinterface

interface zcf_out_if import zcf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 crossing_seen;
  logic                 measurement_done;
  logic [FREQ_BITS-1:0] frequency_centihertz;
  logic [DISP_BITS-1:0] display_value;
  logic [SEG_BITS-1:0]  tens_segments;
  logic [SEG_BITS-1:0]  ones_segments;

  modport source (output valid, output crossing_seen, output measurement_done,
                  output frequency_centihertz, output display_value,
                  output tens_segments, output ones_segments, input ready);
  modport sink   (input valid, input crossing_seen, input measurement_done,
                  input frequency_centihertz, input display_value,
                  input tens_segments, input ones_segments, output ready);
endinterface

interface zcf_cfg_if import zcf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/zcf_front.sv @@
// ----------------------------------------------------------------------------
// zcf_front
// Crossing detection, period accumulation and measurement decision.
// ----------------------------------------------------------------------------
module zcf_front import zcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  zcf_in_if.sink      in_ch,
  zcf_cfg_if.sink     cfg_ch,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [THR_BITS-1:0]     thr_r, thr_nxt;
  logic [PERIODS_BITS-1:0] per_r, per_nxt;
  logic [SAMPLE_BITS-1:0]  prev_r, prev_nxt;
  logic [TIME_BITS-1:0]    ptime_r, ptime_nxt;
  logic                    have_r, have_nxt;
  logic [TIME_BITS-1:0]    sum_r, sum_nxt;
  logic [PERIODS_BITS-1:0] cnt_r, cnt_nxt;

  logic [SAMPLE_BITS-1:0]  thr;
  logic                    crossing;
  logic [TIME_BITS-1:0]    period;
  logic [TIME_BITS:0]      sum_ext;
  logic [TIME_BITS-1:0]    sum_sat;
  logic [PERIODS_BITS-1:0] cnt_inc;
  logic                    reach;
  logic                    accept;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    thr      = SAMPLE_BITS'(thr_r);
    crossing = (prev_r < thr) && (in_ch.sample >= thr);
    period   = in_ch.time_us - ptime_r;
    sum_ext  = {1'b0, sum_r} + {1'b0, period};
    sum_sat  = sum_ext[TIME_BITS] ? '1 : sum_ext[TIME_BITS-1:0];
    cnt_inc  = cnt_r + PERIODS_BITS'(1);
    reach    = (cnt_inc >= per_r) || (cnt_inc == '0);

    thr_nxt   = thr_r;
    per_nxt   = per_r;
    prev_nxt  = prev_r;
    ptime_nxt = ptime_r;
    have_nxt  = have_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;

    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_THRESHOLD: thr_nxt = cfg_ch.data[THR_BITS-1:0];
        CFG_PERIODS:   per_nxt = cfg_ch.data[PERIODS_BITS-1:0];
        default: ;
      endcase
    end

    if (accept) begin
      prev_nxt = in_ch.sample;
      if (crossing) begin
        if (have_r) begin
          sum_nxt = reach ? '0 : sum_sat;
          cnt_nxt = reach ? '0 : cnt_inc;
        end
        ptime_nxt = in_ch.time_us;
        have_nxt  = 1'b1;
      end
    end

    q_push         = accept;
    q_job.crossing = crossing;
    q_job.measure  = crossing && have_r && reach && (sum_sat != '0);
    q_job.numer    = NUM_BITS'(cnt_inc) * NUM_BITS'(CENTI_SCALE);
    q_job.divisor  = sum_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      per_r   <= PERIODS_RESET;
      prev_r  <= '0;
      ptime_r <= '0;
      have_r  <= 1'b0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      thr_r   <= thr_nxt;
      per_r   <= per_nxt;
      prev_r  <= prev_nxt;
      ptime_r <= ptime_nxt;
      have_r  <= have_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/zcf_fifo.sv @@
// ----------------------------------------------------------------------------
// zcf_fifo
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module zcf_fifo import zcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t                     mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                     do_push, do_pop;

  assign full    = (cnt_r == FIFO_CNT_BITS'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                 : wr_ptr_r + FIFO_PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                 : rd_ptr_r + FIFO_PTR_BITS'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + FIFO_CNT_BITS'(1);
      2'b01:   cnt_nxt = cnt_r - FIFO_CNT_BITS'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/zcf_back.sv @@
// ----------------------------------------------------------------------------
// zcf_back
// Restoring divider, held frequency, display scaling and output register.
// ----------------------------------------------------------------------------
module zcf_back import zcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  job_t     q_job,
  output logic     q_pop,
  zcf_out_if.source out_ch
);

  back_state_t          state_r, state_nxt;
  logic                 cross_r, cross_nxt;
  logic                 done_r, done_nxt;
  logic [FREQ_BITS-1:0] held_r, held_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [NUM_BITS-1:0]  quo_r, quo_nxt;
  logic [TIME_BITS-1:0] dsr_r, dsr_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [DISP_BITS-1:0] hz_r, hz_nxt;

  logic                 ov_r, ov_nxt;
  logic                 o_cross_r, o_cross_nxt;
  logic                 o_done_r, o_done_nxt;
  logic [FREQ_BITS-1:0] o_freq_r, o_freq_nxt;
  logic [DISP_BITS-1:0] o_disp_r, o_disp_nxt;
  logic [SEG_BITS-1:0]  o_tens_r, o_tens_nxt;
  logic [SEG_BITS-1:0]  o_ones_r, o_ones_nxt;

  logic [TIME_BITS:0]      rem_sh, diff;
  logic                    ge;
  logic [RND_BITS-1:0]     rnd;
  logic [HZ_PROD_BITS-1:0] hz_prod;
  logic [TEN_PROD_BITS-1:0] ten_prod;
  logic [DIGIT_BITS-1:0]   tens, ones;
  logic                    slot_free;

  assign out_ch.valid                = ov_r;
  assign out_ch.crossing_seen        = o_cross_r;
  assign out_ch.measurement_done     = o_done_r;
  assign out_ch.frequency_centihertz = o_freq_r;
  assign out_ch.display_value        = o_disp_r;
  assign out_ch.tens_segments        = o_tens_r;
  assign out_ch.ones_segments        = o_ones_r;

  always_comb begin
    // one quotient bit per cycle
    rem_sh = {rem_r, quo_r[NUM_BITS-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    ge     = !diff[TIME_BITS];

    rnd      = RND_BITS'(held_r) + ROUND_BIAS;
    hz_prod  = HZ_PROD_BITS'(rnd) * HZ_PROD_BITS'(HZ_RECIP);
    ten_prod = TEN_PROD_BITS'(hz_r) * TEN_PROD_BITS'(TEN_RECIP);
    tens     = DIGIT_BITS'(ten_prod >> TEN_SHIFT);
    ones     = DIGIT_BITS'(hz_r - DISP_BITS'(tens) * DEC_BASE);

    slot_free = !ov_r || out_ch.ready;

    state_nxt   = state_r;
    cross_nxt   = cross_r;
    done_nxt    = done_r;
    held_nxt    = held_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dsr_nxt     = dsr_r;
    step_nxt    = step_r;
    hz_nxt      = hz_r;
    ov_nxt      = ov_r && !out_ch.ready;
    o_cross_nxt = o_cross_r;
    o_done_nxt  = o_done_r;
    o_freq_nxt  = o_freq_r;
    o_disp_nxt  = o_disp_r;
    o_tens_nxt  = o_tens_r;
    o_ones_nxt  = o_ones_r;
    q_pop       = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cross_nxt = q_job.crossing;
          done_nxt  = q_job.measure;
          if (q_job.measure) begin
            rem_nxt   = '0;
            quo_nxt   = q_job.numer;
            dsr_nxt   = q_job.divisor;
            step_nxt  = '0;
            state_nxt = BK_DIV;
          end else begin
            state_nxt = BK_SCALE;
          end
        end
      end
      BK_DIV: begin
        rem_nxt  = ge ? diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
        quo_nxt  = {quo_r[NUM_BITS-2:0], ge};
        step_nxt = step_r + STEP_BITS'(1);
        if (step_r == STEP_BITS'(NUM_BITS - 1)) begin
          state_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        held_nxt  = (quo_r > NUM_BITS'(FREQ_MAX)) ? FREQ_MAX : quo_r[FREQ_BITS-1:0];
        state_nxt = BK_SCALE;
      end
      BK_SCALE: begin
        hz_nxt    = (held_r >= ROUND_LIMIT) ? DISP_MAX : DISP_BITS'(hz_prod >> HZ_SHIFT);
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          ov_nxt      = 1'b1;
          o_cross_nxt = cross_r;
          o_done_nxt  = done_r;
          o_freq_nxt  = held_r;
          o_disp_nxt  = hz_r;
          o_tens_nxt  = seg7(tens);
          o_ones_nxt  = seg7(ones);
          state_nxt   = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      held_r  <= HELD_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cross_r   <= cross_nxt;
    done_r    <= done_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    dsr_r     <= dsr_nxt;
    step_r    <= step_nxt;
    hz_r      <= hz_nxt;
    o_cross_r <= o_cross_nxt;
    o_done_r  <= o_done_nxt;
    o_freq_r  <= o_freq_nxt;
    o_disp_r  <= o_disp_nxt;
    o_tens_r  <= o_tens_nxt;
    o_ones_r  <= o_ones_nxt;
  end

endmodule

@@ hw/rtl/zero_cross_frequency_meter.sv @@
// ----------------------------------------------------------------------------
// zero_cross_frequency_meter
// Reciprocal frequency meter with a two-digit seven-segment readout.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per converter sample {sample, time_us}.
//   out_ch : exactly one result per accepted sample, in order: crossing flag,
//            measurement flag, held frequency in centihertz, rounded hertz
//            and the two digit patterns.
//   cfg_ch : register writes, index 0 = crossing threshold, 1 = periods per
//            measurement; always ready, write only while the block is idle.
// Path: an accepted sample is queued, then the back end takes it and runs
//   scale and emit; a sample that closes a measurement first runs the 35-step
//   restoring divider (one quotient bit per cycle) and load before scale.
// Pacing: the back end takes the next request from the queue only after it
//   has emitted the last one, and emit waits while out_ch is stalled.
// A two-entry queue lets the front keep accepting while the back divides or
// waits; the front stalls in_ch only when the queue is full.
// Reset: synchronous, active low. Threshold 2048, 5 periods, held frequency
//   50 Hz, no crossing seen yet, queue and output register empty.
// Stall: a held result stays on out_ch unchanged until taken; the back end
//   then waits and the queue fills before in_ch.ready drops.
// ----------------------------------------------------------------------------
module zero_cross_frequency_meter import zcf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  zcf_in_if.sink    in_ch,
  zcf_out_if.source out_ch,
  zcf_cfg_if.sink   cfg_ch
);

  // front -> queue
  logic q_push;
  job_t q_push_job;
  logic q_full;

  // queue -> back
  logic q_pop;
  job_t q_pop_job;
  logic q_empty;

  // Front: threshold compare, period sum and count, measurement decision.
  zcf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_push_job)
  );

  // Decoupling queue between classification and division.
  zcf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .empty    (q_empty)
  );

  // Back: divide, hold frequency, format display, drive out_ch.
  zcf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (q_pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ hw/rtl/zcf_checker.sv @@
// ----------------------------------------------------------------------------
// zcf_checker
// Port-level assertions for the zero-cross frequency meter.
// ----------------------------------------------------------------------------
module zcf_checker import zcf_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 crossing_seen,
  input logic                 measurement_done,
  input logic [FREQ_BITS-1:0] frequency_centihertz,
  input logic [DISP_BITS-1:0] display_value,
  input logic [SEG_BITS-1:0]  tens_segments,
  input logic [SEG_BITS-1:0]  ones_segments
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frequency_centihertz)
      && $stable(display_value) && $stable(tens_segments) && $stable(ones_segments))
    else $error("result changed while stalled");

  // a new measurement only happens on a crossing
  a_done_cross: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && measurement_done |-> crossing_seen)
    else $error("measurement without crossing");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> display_value <= DISP_MAX && frequency_centihertz <= FREQ_MAX)
    else $error("result out of range");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frequency_centihertz >= ROUND_LIMIT |-> display_value == DISP_MAX)
    else $error("display not clamped");

endmodule

bind zero_cross_frequency_meter zcf_checker u_zcf_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .crossing_seen        (out_ch.crossing_seen),
  .measurement_done     (out_ch.measurement_done),
  .frequency_centihertz (out_ch.frequency_centihertz),
  .display_value        (out_ch.display_value),
  .tens_segments        (out_ch.tens_segments),
  .ones_segments        (out_ch.ones_segments)
);

@@ sim/zero_cross_frequency_meter_tb.sv @@
// ----------------------------------------------------------------------------
// zero_cross_frequency_meter_tb
// Self-checking bench for the zero-cross frequency meter. Timestamped samples
// go in over a valid/ready channel. A scoreboard class predicts every readout:
// crossing flag, measurement flag, held centihertz, rounded hertz and the two
// digit patterns. Each readout from the block is checked against it in order.
// ----------------------------------------------------------------------------
module zero_cross_frequency_meter_tb;
  import zcf_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 50;
  localparam int HOLD_OFF_AT     = 150;     // readouts taken before the long stall
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int REPORT_MAX      = 10;
  localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

  typedef struct packed {
    logic                 crossing_seen;
    logic                 measurement_done;
    logic [FREQ_BITS-1:0] frequency_centihertz;
    logic [DISP_BITS-1:0] display_value;
    logic [SEG_BITS-1:0]  tens_segments;
    logic [SEG_BITS-1:0]  ones_segments;
  } readout_t;

  // Scoreboard: its own copy of the meter state and registers, plus the
  // queue of readouts still owed by the block.
  class freq_scoreboard;
    logic [THR_BITS-1:0]     level_thr;
    logic [PERIODS_BITS-1:0] period_target;
    logic [SAMPLE_BITS-1:0]  last_sample;
    logic [TIME_BITS-1:0]    last_cross_us;
    logic                    armed;
    logic [TIME_BITS-1:0]    period_sum;
    logic [PERIODS_BITS-1:0] period_cnt;
    logic [FREQ_BITS-1:0]    held_freq;
    logic [SEG_BITS-1:0]     glyph [10];
    readout_t                readout_q [$];
    int                      mismatches;

    function new();
      level_thr     = THR_RESET;
      period_target = PERIODS_RESET;
      last_sample   = '0;
      last_cross_us = '0;
      armed         = 1'b0;
      period_sum    = '0;
      period_cnt    = '0;
      held_freq     = HELD_RESET;
      glyph = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
      mismatches = 0;
    endfunction

    function void apply_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_THRESHOLD: level_thr = data[THR_BITS-1:0];
        CFG_PERIODS:   period_target = data[PERIODS_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Advance the meter by one accepted sample and queue the readout it owes.
    function void note_sample(logic [SAMPLE_BITS-1:0] smp, logic [TIME_BITS-1:0] t_us);
      logic                 hit;
      logic                 done;
      logic [TIME_BITS-1:0] period;
      logic [TIME_BITS-1:0] room;
      logic [63:0]          numer;
      logic [63:0]          denom;
      logic [63:0]          quot;
      logic [31:0]          hz;
      readout_t             r;
      hit  = (last_sample < level_thr) && (smp >= level_thr);
      done = 1'b0;
      if (hit) begin
        if (armed) begin
          period     = t_us - last_cross_us;   // wraps with the timestamp
          room       = TIME_TOP - period_sum;
          period_sum = (period > room) ? TIME_TOP : period_sum + period;
          period_cnt = period_cnt + 1'b1;
          if (period_cnt >= period_target || period_cnt == '0) begin
            if (period_sum != '0) begin
              numer = '0;
              numer[PERIODS_BITS-1:0] = period_cnt;
              numer = numer * 64'd100000000;
              denom = '0;
              denom[TIME_BITS-1:0] = period_sum;
              quot  = numer / denom;
              held_freq = (quot > {37'd0, FREQ_MAX}) ? FREQ_MAX : quot[FREQ_BITS-1:0];
              done = 1'b1;
            end
            period_sum = '0;
            period_cnt = '0;
          end
        end
        last_cross_us = t_us;
        armed = 1'b1;
      end
      last_sample = smp;
      hz = {5'd0, held_freq} + 32'd50;
      hz = hz / 32'd100;
      if (hz > 32'd99) hz = 32'd99;
      r.crossing_seen        = hit;
      r.measurement_done     = done;
      r.frequency_centihertz = held_freq;
      r.display_value        = hz[DISP_BITS-1:0];
      r.tens_segments        = glyph[hz / 10];
      r.ones_segments        = glyph[hz % 10];
      readout_q.push_back(r);
    endfunction

    function string show(readout_t r);
      return $sformatf("cross=%0d done=%0d freq=%0d hz=%0d tens=%h ones=%h",
                       r.crossing_seen, r.measurement_done, r.frequency_centihertz,
                       r.display_value, r.tens_segments, r.ones_segments);
    endfunction

    function void check_readout(readout_t got);
      readout_t want;
      logic     bad;
      if (readout_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("readout with no sample pending: %s", show(got));
        return;
      end
      want = readout_q.pop_front();
      bad = (got.crossing_seen        !== want.crossing_seen)        ||
            (got.measurement_done     !== want.measurement_done)     ||
            (got.frequency_centihertz !== want.frequency_centihertz) ||
            (got.display_value        !== want.display_value)        ||
            (got.tens_segments        !== want.tens_segments)        ||
            (got.ones_segments        !== want.ones_segments);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("readout mismatch\n  expected %s\n  actual   %s", show(want), show(got));
      end
    endfunction

    function int pending();
      return readout_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  zcf_in_if  in_ch ();
  zcf_out_if out_ch ();
  zcf_cfg_if cfg_ch ();

  zero_cross_frequency_meter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  freq_scoreboard       board;
  bit                   calm;            // no idling on either side when set
  int                   readouts_taken = 0;
  int                   cycle_count = 0;
  logic [TIME_BITS-1:0] now_us;          // running timestamp of the waveform

  always #10 clk = ~clk;

  // Watchdog: a stuck handshake or a lost readout ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One sample request. An optional idle burst precedes it; valid then stays
  // high until the request is taken, so back-to-back requests never drop it.
  // Handshake signals are read right after the edge, i.e. their values at it.
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp,
                             input logic [TIME_BITS-1:0] t_us);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= smp;
    in_ch.time_us <= t_us;
    do @(posedge clk); while (!in_ch.ready);
    board.note_sample(smp, t_us);
  endtask

  // Drop the sample request and wait for every owed readout. Each sample
  // yields a readout, so an empty queue means the block is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Register write; the cycle after it keeps valid edges apart.
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.apply_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hand-picked corners: first crossing, wrap, zero sum, overflow clamp,
  // saturating sum, period count of zero, both ends of the threshold.
  task automatic run_directed();
    // reset setting: first crossing only arms, the next closes one period
    push_sample(12'd0,    40'd0);
    push_sample(12'hFFF,  40'd1000);
    push_sample(12'd2047, 40'd2000);
    push_sample(12'd2048, 40'd3000);        // lands exactly on the level
    // upper data bits are dropped: one period per measurement
    settle();
    cfg_write(CFG_PERIODS, 12'hF01);
    push_sample(12'd0,   TIME_TOP - 40'd15);
    push_sample(12'hFFF, TIME_TOP - 40'd15); // near-full-range period -> 0 Hz
    push_sample(12'd0,   40'd0);
    push_sample(12'hFFF, 40'h10);            // timestamp wraps, 32 us period
    push_sample(12'd0,   40'h10);
    push_sample(12'hFFF, 40'h10);            // zero period: old value held
    // two periods: sum of one microsecond overflows the frequency range
    settle();
    cfg_write(CFG_PERIODS, 12'd2);
    push_sample(12'd0,   40'h10);
    push_sample(12'hFFF, 40'h11);
    push_sample(12'd0,   40'h11);
    push_sample(12'hFFF, 40'h11);
    // two full-range periods saturate the sum
    push_sample(12'd0,   40'h11);
    push_sample(12'hFFF, 40'h10);
    push_sample(12'd0,   40'h10);
    push_sample(12'hFFF, 40'h0F);
    // period count of zero behaves like one
    settle();
    cfg_write(CFG_PERIODS, 12'h100);
    push_sample(12'd0,   40'h0F);
    push_sample(12'hFFF, 40'd20015);         // 50 Hz
    // top threshold: only full scale crosses
    settle();
    cfg_write(CFG_THRESHOLD, 12'hFFF);
    push_sample(12'hFFE, 40'd30000);
    push_sample(12'hFFF, 40'd40000);
    // zero threshold: nothing can be below it, so no crossing
    settle();
    cfg_write(CFG_THRESHOLD, 12'h000);
    push_sample(12'd0,   40'd50000);
    push_sample(12'hFFF, 40'd60000);
  endtask

  // Random phase: mostly whole wave cycles (low samples then high ones) at a
  // random period, mixed with noise samples and stray timestamps.
  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] thr_data,
                           input logic [CFG_DATA_BITS-1:0] periods_data,
                           input int n_items, input bit quiet);
    int                     sent;
    int                     n_low;
    int                     n_all;
    int unsigned            period;
    int unsigned            step;
    logic [31:0]            rnd;
    logic [31:0]            rnd_hi;
    logic [SAMPLE_BITS-1:0] smp;
    logic [TIME_BITS-1:0]   wild_us;
    settle();
    cfg_write(CFG_THRESHOLD, thr_data);
    cfg_write(CFG_PERIODS, periods_data);
    calm = quiet;
    if ($urandom_range(0, 2) == 0) begin
      rnd    = $urandom_range(0, 2000000);
      now_us = TIME_TOP - {8'd0, rnd};       // run across the timestamp wrap
    end
    sent = 0;
    while (sent < n_items) begin
      if (thr_data[THR_BITS-1:0] != '0 && $urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 19))
          0:       period = $urandom_range(1, 200);            // far above 99 Hz
          1:       period = $urandom_range(1000000, 50000000); // below 1 Hz
          default: period = $urandom_range(9000, 1000000);     // roughly 1 Hz to 111 Hz
        endcase
        n_low = $urandom_range(1, 3);
        n_all = n_low + $urandom_range(1, 3);
        step  = period / n_all;
        for (int k = 0; k < n_all; k++) begin
          if (k < n_low) rnd = $urandom_range(0, thr_data[THR_BITS-1:0] - 1);
          else           rnd = $urandom_range(thr_data[THR_BITS-1:0], 4095);
          smp    = rnd[SAMPLE_BITS-1:0];
          now_us = now_us + {8'd0, step};
          push_sample(smp, now_us);
        end
        sent += n_all;
      end else begin
        rnd = $urandom_range(0, 4095);
        smp = rnd[SAMPLE_BITS-1:0];
        if ($urandom_range(0, 1) == 0) begin
          rnd    = $urandom_range(0, 5000);
          now_us = now_us + {8'd0, rnd};
          push_sample(smp, now_us);
        end else begin
          rnd     = $urandom;
          rnd_hi  = $urandom;
          wild_us = {rnd_hi[7:0], rnd};      // stray timestamp, breaks the rhythm
          push_sample(smp, wild_us);
        end
        sent++;
      end
    end
  endtask

  // Result side: random stall bursts, one long hold-off that backs the block
  // up into its input, and a check of every readout taken.
  initial begin : result_sink
    int       stall_left;
    bit       held_off;
    readout_t got;
    stall_left = 0;
    held_off   = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!held_off && readouts_taken >= HOLD_OFF_AT) begin
        held_off   = 1'b1;
        stall_left = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.crossing_seen, out_ch.measurement_done, out_ch.frequency_centihertz,
               out_ch.display_value, out_ch.tens_segments, out_ch.ones_segments};
        readouts_taken++;
        board.check_readout(got);
      end
    end
  end

  // Main sequence: reset, directed corners, random phases over several
  // register settings (extremes included), then drain and report.
  initial begin : stimulus
    logic [31:0] rnd;
    board = new();
    calm  = 1'b0;
    now_us = 40'd100000;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.time_us <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_THRESHOLD;
    cfg_ch.data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    now_us = 40'd100000;

    run_phase(12'd2048, 12'd5,    100, 1'b0);
    run_phase(12'd1,    12'hF01,  100, 1'b0);   // lowest usable level, one period
    run_phase(12'hFFF,  12'd3,     60, 1'b0);
    rnd = $urandom_range(1, 4095);
    run_phase(rnd[CFG_DATA_BITS-1:0], 12'd0 + 12'($urandom_range(1, 8)), 120, 1'b0);
    run_phase(12'd700,  12'd255,   60, 1'b0);   // longest measurement window
    run_phase(12'd3000, 12'h100,  100, 1'b0);   // period count of zero
    run_phase(12'd2048, 12'd2,    110, 1'b1);   // closing stretch, no idling

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/zcf_pkg.sv
hw/rtl/zcf_if.sv
hw/rtl/zcf_front.sv
hw/rtl/zcf_fifo.sv
hw/rtl/zcf_back.sv
hw/rtl/zero_cross_frequency_meter.sv
hw/rtl/zcf_checker.sv
sim/zero_cross_frequency_meter_tb.sv
